// File: src/hdlcd_pkg.sv
package hdlcd_pkg;

  localparam int unsigned MAX_FRAME = 4096;
  localparam int unsigned CNT_W = 13;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_XOR = 8'h20;

  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_POLY = 16'h8408;
  localparam logic [15:0] FCS_GOOD = 16'hF0B8;

  localparam logic [CNT_W-1:0] MAX_FRAME_CNT = CNT_W'(MAX_FRAME);
  localparam logic [CNT_W-1:0] MIN_FRAME_CNT = CNT_W'(2);

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD = 2'd2;
  localparam logic [1:0] KIND_ABORT = 2'd3;

  // reflected ccitt fcs-16, one byte
  function automatic logic [15:0] fcs_update(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] f;
    f = fcs ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (f[0]) begin
        f = (f >> 1) ^ FCS_POLY;
      end else begin
        f = f >> 1;
      end
    end
    return f;
  endfunction

endpackage

// File: src/hdlc_async_deframer_core.sv
// path: an accepted input item passes the input register, then the result register
// throughput: one input item per cycle unless a waiting result stalls it; the
//   byte-wide fcs update and unstuffing are combinational between those registers
// escape bytes, bytes after overflow and stalled slots give no result
// reset: asynchronous active low; fcs to 0xffff, counts, flags and held bytes to 0
module hdlc_async_deframer_core import hdlcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  payload_o,
  output logic [12:0] frame_length_o,
  output logic [15:0] fcs_error_count_o,
  output logic [15:0] abort_count_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // frame state
  logic             esc_q, esc_d;
  logic [15:0]      fcs_q, fcs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;
  logic [7:0]       held0_q, held0_d, held1_q, held1_d;
  logic [15:0]      bad_q, bad_d, abort_q, abort_d;

  // result register
  logic        out_valid_q;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  payload_q, payload_d;
  logic [12:0] len_q, len_d;
  logic [15:0] bad_out_q, abort_out_q;

  logic       advance;
  logic       has_res;
  logic [7:0] data_b;

  assign advance = in_valid_q && (!out_valid_q || res_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    esc_d     = esc_q;
    fcs_d     = fcs_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    held0_d   = held0_q;
    held1_d   = held1_q;
    bad_d     = bad_q;
    abort_d   = abort_q;
    has_res   = 1'b0;
    kind_d    = KIND_DATA;
    payload_d = 8'h00;
    len_d     = 13'd0;
    data_b    = in_byte_q;
    if (in_byte_q == FLAG_BYTE) begin
      has_res = 1'b1;
      len_d   = (cnt_q >= MIN_FRAME_CNT) ? 13'(cnt_q - MIN_FRAME_CNT) : 13'd0;
      priority if (esc_q) begin
        esc_d   = 1'b0;
        abort_d = abort_q + 16'd1;
        kind_d  = KIND_ABORT;
      end else if (cnt_q >= MIN_FRAME_CNT && fcs_q == FCS_GOOD && !ovf_q) begin
        kind_d = KIND_GOOD;
      end else begin
        bad_d  = bad_q + 16'd1;
        kind_d = KIND_BAD;
      end
      fcs_d   = FCS_INIT;
      cnt_d   = '0;
      ovf_d   = 1'b0;
      held0_d = 8'h00;
      held1_d = 8'h00;
    end else if (!esc_q && in_byte_q == ESC_BYTE) begin
      esc_d = 1'b1;
    end else begin
      if (esc_q) begin
        esc_d  = 1'b0;
        data_b = in_byte_q ^ ESC_XOR;
      end
      if (!ovf_q) begin
        if (cnt_q >= MIN_FRAME_CNT) begin
          has_res   = 1'b1;
          payload_d = held0_q;
        end
        held0_d = held1_q;
        held1_d = data_b;
        fcs_d   = fcs_update(fcs_q, data_b);
        cnt_d   = cnt_q + CNT_W'(1);
        if (cnt_d >= MAX_FRAME_CNT) begin
          ovf_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      in_byte_q   <= 8'h00;
      esc_q       <= 1'b0;
      fcs_q       <= FCS_INIT;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      held0_q     <= 8'h00;
      held1_q     <= 8'h00;
      bad_q       <= 16'd0;
      abort_q     <= 16'd0;
      out_valid_q <= 1'b0;
      kind_q      <= KIND_DATA;
      payload_q   <= 8'h00;
      len_q       <= 13'd0;
      bad_out_q   <= 16'd0;
      abort_out_q <= 16'd0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
        if (in_valid_i) begin
          in_byte_q <= rx_byte_i;
        end
      end
      if (advance) begin
        esc_q       <= esc_d;
        fcs_q       <= fcs_d;
        cnt_q       <= cnt_d;
        ovf_q       <= ovf_d;
        held0_q     <= held0_d;
        held1_q     <= held1_d;
        bad_q       <= bad_d;
        abort_q     <= abort_d;
        out_valid_q <= has_res;
        if (has_res) begin
          kind_q      <= kind_d;
          payload_q   <= payload_d;
          len_q       <= len_d;
          bad_out_q   <= bad_d;
          abort_out_q <= abort_d;
        end
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign payload_o         = payload_q;
  assign frame_length_o    = len_q;
  assign fcs_error_count_o = bad_out_q;
  assign abort_count_o     = abort_out_q;

  a_ovf_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == MAX_FRAME_CNT)
    else $error("overflow flag without full count");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MAX_FRAME_CNT)
    else $error("byte count beyond frame limit");

  a_end_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q != KIND_DATA |-> payload_q == 8'h00)
    else $error("end item carries payload");

  a_data_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_DATA |-> len_q == 13'd0)
    else $error("payload item carries length");

  a_stall_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("input register lost a stalled item");

endmodule

// File: tb/tb_hdlc_async_deframer_core.sv
`timescale 1ns / 100ps

module tb_hdlc_async_deframer_core import hdlcd_pkg::*; ();

  localparam int QUIET_LIMIT = 1000;
  localparam int RANDOM_ITEMS = 1420;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [12:0] len;
    logic [15:0] bad_total;
    logic [15:0] abort_total;
  } deframer_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        res_valid_o;
  logic        res_ready_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_o;
  logic [12:0] frame_length_o;
  logic [15:0] fcs_error_count_o;
  logic [15:0] abort_count_o;

  hdlc_async_deframer_core DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .res_valid_o       (res_valid_o),
    .res_ready_i       (res_ready_i),
    .kind_o            (kind_o),
    .payload_o         (payload_o),
    .frame_length_o    (frame_length_o),
    .fcs_error_count_o (fcs_error_count_o),
    .abort_count_o     (abort_count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // receive-side state mirror
  bit               rx_escaped;
  logic [15:0]      rx_fcs;
  int               rx_count;
  bit               rx_overflow;
  logic [7:0]       held_old;
  logic [7:0]       held_new;
  logic [15:0]      bad_frames_seen;
  logic [15:0]      aborts_seen;
  deframer_result_t pending_reports[$];

  bit               idle_on = 1'b1;
  int               items_sent = 0;
  int               mismatches = 0;
  int               quiet_cycles = 0;
  int               stall_left = 0;
  logic [7:0]       frame_body[$];

  function automatic logic [15:0] fcs16_next(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ FCS_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic clear_frame();
    rx_fcs = FCS_INIT;
    rx_count = 0;
    rx_overflow = 1'b0;
    held_old = 8'h00;
    held_new = 8'h00;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    deframer_result_t r;
    logic [7:0] d;
    r = '0;
    d = b;
    if (b == FLAG_BYTE) begin
      r.len = (rx_count >= 2) ? 13'(rx_count - 2) : 13'd0;
      if (rx_escaped) begin
        rx_escaped = 1'b0;
        aborts_seen = aborts_seen + 16'd1;
        r.kind = KIND_ABORT;
      end else if (rx_count >= 2 && rx_fcs == FCS_GOOD && !rx_overflow) begin
        r.kind = KIND_GOOD;
      end else begin
        bad_frames_seen = bad_frames_seen + 16'd1;
        r.kind = KIND_BAD;
      end
      r.bad_total = bad_frames_seen;
      r.abort_total = aborts_seen;
      pending_reports = {pending_reports, r};
      clear_frame();
      return;
    end
    if (rx_escaped) begin
      rx_escaped = 1'b0;
      d = b ^ ESC_XOR;
    end else if (b == ESC_BYTE) begin
      rx_escaped = 1'b1;
      return;
    end
    if (rx_overflow) return;
    if (rx_count >= 2) begin
      r.kind = KIND_DATA;
      r.data = held_old;
      r.bad_total = bad_frames_seen;
      r.abort_total = aborts_seen;
      pending_reports = {pending_reports, r};
    end
    held_old = held_new;
    held_new = d;
    rx_fcs = fcs16_next(rx_fcs, d);
    rx_count++;
    if (rx_count >= MAX_FRAME) rx_overflow = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    deframe_byte(b);
  endtask

  task automatic send_data(input logic [7:0] d, input bit stuff_rand);
    if (d == FLAG_BYTE || d == ESC_BYTE || (stuff_rand && $urandom_range(0, 7) == 0)) begin
      send_byte(ESC_BYTE);
      send_byte(d ^ ESC_XOR);
    end else begin
      send_byte(d);
    end
  endtask

  // sends frame_body, its fcs, an escape byte if abort_it, and the closing flag
  task automatic send_frame(input bit fcs_ok, input bit abort_it, input bit stuff_rand);
    logic [15:0] c;
    c = FCS_INIT;
    foreach (frame_body[k]) c = fcs16_next(c, frame_body[k]);
    c = ~c;
    if (!fcs_ok) c = c ^ (16'h0001 << $urandom_range(0, 15));
    foreach (frame_body[k]) send_data(frame_body[k], stuff_rand);
    send_data(c[7:0], stuff_rand);
    send_data(c[15:8], stuff_rand);
    if (abort_it) send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
  endtask

  task automatic fill_body(input int n);
    frame_body.delete();
    repeat (n) frame_body = {frame_body, pick_byte()};
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_directed();
    // back-to-back flags
    send_byte(FLAG_BYTE);
    send_byte(FLAG_BYTE);
    // empty payload with good fcs
    frame_body.delete();
    send_frame(1'b1, 1'b0, 1'b0);
    // extremes and stuffed data
    frame_body = {8'h00, 8'hFF, FLAG_BYTE, ESC_BYTE};
    send_frame(1'b1, 1'b0, 1'b0);
    // short frame
    send_byte(8'hA5);
    send_byte(FLAG_BYTE);
    // bad fcs
    frame_body = {8'h11, 8'h22};
    send_frame(1'b0, 1'b0, 1'b0);
    // escape right before flag
    send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
    // escaped plain byte and escaped escape
    send_byte(ESC_BYTE);
    send_byte(8'h00);
    send_byte(ESC_BYTE);
    send_byte(ESC_BYTE);
    send_byte(FLAG_BYTE);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    bit drained;
    start = items_sent;
    drained = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      if (!drained && items_sent - start >= RANDOM_ITEMS / 2) begin
        wait_drained();
        drained = 1'b1;
      end
      if (items_sent - start >= RANDOM_ITEMS - 250) idle_on = 1'b0;
      pick = $urandom_range(0, 15);
      if (pick <= 12) begin
        fill_body(($urandom_range(0, 15) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 12));
        send_frame(pick <= 9, pick == 12, 1'b1);
      end else if (pick == 13) begin
        if ($urandom_range(0, 1)) send_data(pick_byte(), 1'b1);
        send_byte(FLAG_BYTE);
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(($urandom_range(0, 3) == 0) ? pick_byte()
                                                                          : 8'($urandom));
      end
    end
    send_byte(FLAG_BYTE);
  endtask

  task automatic note_mismatch(input string what, input deframer_result_t want,
                               input deframer_result_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %s: expected kind %0d data %02h len %0d bad %0d abort %0d",
               what, want.kind, want.data, want.len, want.bad_total, want.abort_total);
      $display("  actual kind %0d data %02h len %0d bad %0d abort %0d",
               seen.kind, seen.data, seen.len, seen.bad_total, seen.abort_total);
    end
  endtask

  always @(posedge clk_i) begin
    deframer_result_t seen;
    deframer_result_t want;
    if (rst_ni && res_valid_o && res_ready_i) begin
      seen = {kind_o, payload_o, frame_length_o, fcs_error_count_o, abort_count_o};
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected item", '0, seen);
      end else begin
        want = pending_reports.pop_front();
        if (seen.kind !== want.kind || seen.data !== want.data || seen.len !== want.len ||
            seen.bad_total !== want.bad_total || seen.abort_total !== want.abort_total)
          note_mismatch("field", want, seen);
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 8);
      res_ready_i <= 1'b0;
    end else begin
      res_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (res_valid_o && res_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_escaped = 1'b0;
    bad_frames_seen = 16'd0;
    aborts_seen = 16'd0;
    clear_frame();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
